@@ src/flr_pkg.sv @@
// ---------------------------------------------------------------------------
// flr_pkg
// Shared types, codes and constants of the folded line reader.
// ---------------------------------------------------------------------------
package flr_pkg;

	localparam int unsigned FLR_QUEUE_DEPTH = 4;

	localparam logic [1:0] PH_LINE = 2'd0;
	localparam logic [1:0] PH_LOOK = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_BLANK  = 3'd1;
	localparam logic [2:0] ST_RESYNC = 3'd2;
	localparam logic [2:0] ST_LONG   = 3'd3;
	localparam logic [2:0] ST_EOF    = 3'd4;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [0:0] REG_MAX_LINE = 1'd0;
	localparam logic [0:0] REG_RAW_MODE = 1'd1;

	localparam logic [15:0] MAX_LINE_RESET = 16'd1024;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} flr_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       line_end;
		logic [2:0] status;
	} flr_out_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [15:0] char_count;
		logic [1:0]  n;
		flr_out_t    r0;
		flr_out_t    r1;
	} flr_step_t;

	function automatic flr_out_t mk_char(input logic [7:0] b);
		flr_out_t r;
		r.out_byte = b;
		r.line_end = 1'b0;
		r.status   = ST_OK;
		return r;
	endfunction

	function automatic flr_out_t mk_end(input logic [2:0] st);
		flr_out_t r;
		r.out_byte = 8'd0;
		r.line_end = 1'b1;
		r.status   = st;
		return r;
	endfunction

endpackage

@@ src/flr_step.sv @@
// ---------------------------------------------------------------------------
// flr_step
// Per-byte line logic: next phase, next count and up to two results.
// ---------------------------------------------------------------------------
module flr_step (
	input  flr_pkg::flr_in_t  item,
	input  logic [1:0]        phase,
	input  logic [15:0]       char_count,
	input  logic [15:0]       max_line,
	input  logic              raw_mode,
	output flr_pkg::flr_step_t step
);
	import flr_pkg::*;

	logic [15:0] limit;
	logic [15:0] base;
	logic [15:0] c1;
	logic [2:0]  done_st;
	logic [1:0]  lb_n;
	flr_out_t    lb_r0;
	flr_out_t    lb_r1;
	logic [1:0]  lb_phase;
	logic [15:0] lb_count;
	logic        is_blank;

	assign limit    = ((max_line < 16'd3) ? 16'd3 : max_line) - 16'd1;
	assign done_st  = (char_count == 16'd1) ? ST_BLANK : ST_OK;
	assign base     = (phase == PH_LOOK) ? 16'd0 : char_count;
	assign c1       = base + 16'd1;
	assign is_blank = (item.in_byte == CH_SPACE) || (item.in_byte == CH_TAB);

	// line byte handling against a base count
	always_comb begin
		lb_n     = 2'd0;
		lb_r0    = mk_end(ST_OK);
		lb_r1    = mk_end(ST_OK);
		lb_phase = PH_LINE;
		lb_count = c1;
		if (item.in_byte == CH_NUL) begin
			lb_n     = 2'd1;
			lb_r0    = mk_end(ST_RESYNC);
			lb_count = 16'd0;
		end else if (item.in_byte == CH_NL) begin
			if (raw_mode) begin
				lb_n     = 2'd1;
				lb_r0    = mk_end((c1 == 16'd1) ? ST_BLANK : ST_OK);
				lb_count = 16'd0;
			end else begin
				lb_phase = PH_LOOK;
			end
		end else begin
			lb_n  = 2'd1;
			lb_r0 = mk_char(item.in_byte);
			if (c1 >= limit) begin
				lb_n     = 2'd2;
				lb_r1    = mk_end(ST_LONG);
				lb_count = 16'd0;
			end
		end
	end

	always_comb begin
		step.phase      = phase;
		step.char_count = char_count;
		step.n          = 2'd0;
		step.r0         = mk_end(ST_OK);
		step.r1         = mk_end(ST_OK);
		if (item.kind) begin
			step.phase      = PH_LINE;
			step.char_count = 16'd0;
			if (phase == PH_LOOK || phase == PH_SKIP) begin
				step.n  = 2'd2;
				step.r0 = mk_end(done_st);
				step.r1 = mk_end(ST_EOF);
			end else begin
				step.n  = 2'd1;
				step.r0 = mk_end(ST_EOF);
			end
		end else begin
			unique case (phase)
				PH_SKIP: begin
					if (item.in_byte == CH_NL) begin
						step.phase = PH_LOOK;
					end
				end
				PH_LOOK: begin
					if (item.in_byte == CH_HASH) begin
						step.phase = PH_SKIP;
					end else if (is_blank) begin
						step.phase = PH_LINE;
						step.n     = 2'd1;
						step.r0    = mk_char(CH_SPACE);
						if (char_count >= limit) begin
							step.n          = 2'd2;
							step.r1         = mk_end(ST_LONG);
							step.char_count = 16'd0;
						end
					end else begin
						step.phase      = lb_phase;
						step.char_count = lb_count;
						step.n          = lb_n + 2'd1;
						step.r0         = mk_end(done_st);
						step.r1         = lb_r0;
					end
				end
				default: begin
					step.phase      = lb_phase;
					step.char_count = lb_count;
					step.n          = lb_n;
					step.r0         = lb_r0;
					step.r1         = lb_r1;
				end
			endcase
		end
	end

endmodule

@@ src/flr_out_queue.sv @@
// ---------------------------------------------------------------------------
// flr_out_queue
// Result queue: takes up to two results a cycle, hands out one unless stalled.
// ---------------------------------------------------------------------------
module flr_out_queue #(
	parameter int unsigned DEPTH = flr_pkg::FLR_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  flr_pkg::flr_out_t push_r0,
	input  flr_pkg::flr_out_t push_r1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_stall,
	output flr_pkg::flr_out_t out_item
);
	import flr_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	flr_out_t    mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] wr1;
	logic [AW-1:0] wr2;
	logic [AW-1:0] rd1;
	logic          pop;

	assign wr1       = (wr_q == LAST) ? '0 : wr_q + AW'(1);
	assign wr2       = (wr1 == LAST) ? '0 : wr1 + AW'(1);
	assign rd1       = (rd_q == LAST) ? '0 : rd_q + AW'(1);
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push_r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr1] <= push_r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			unique case (push_n)
				2'd1:    wr_q <= wr1;
				2'd2:    wr_q <= wr2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd1;
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

@@ src/folded_line_reader.sv @@
// ---------------------------------------------------------------------------
// folded_line_reader
// Byte-stream line reader with continuation folding and comment skipping.
// An accepted byte is registered in the input stage, then its results are
// written into the result queue, which offers them in order after any older results.
// Throughput: one byte per cycle unless stalled; two results of one byte leave
// singly; the result queue absorbs this and stalls input when nearly full.
// Reset: phase in line, count zero, max_line 1024, raw_mode 0, queue empty.
// ---------------------------------------------------------------------------
module folded_line_reader #(
	parameter int unsigned QUEUE_DEPTH = flr_pkg::FLR_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  flr_pkg::flr_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output flr_pkg::flr_out_t out_item,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import flr_pkg::*;

	flr_in_t     item_s1;
	logic        valid_s1;
	logic [1:0]  phase_q;
	logic [15:0] count_q;
	logic [15:0] max_line_q;
	logic        raw_mode_q;
	flr_step_t   step;
	logic        room;
	logic        go;

	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			phase_q    <= PH_LINE;
			count_q    <= '0;
			max_line_q <= MAX_LINE_RESET;
			raw_mode_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				phase_q <= step.phase;
				count_q <= step.char_count;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_LINE: max_line_q <= cfg_data;
					REG_RAW_MODE: raw_mode_q <= cfg_data[0];
					default:      max_line_q <= max_line_q;
				endcase
			end
		end
	end

	flr_step u_step (
		.item       (item_s1),
		.phase      (phase_q),
		.char_count (count_q),
		.max_line   (max_line_q),
		.raw_mode   (raw_mode_q),
		.step       (step)
	);

	flr_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (go ? step.n : 2'd0),
		.push_r0   (step.r0),
		.push_r1   (step.r1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ test/flr_stream_checker.sv @@
// ---------------------------------------------------------------------------
// flr_stream_checker
// Watches the byte and result channels of the folded line reader, keeps its
// own model of the unfolding state and the two registers, and compares each
// accepted result with the oldest one predicted. Mismatches, unexpected
// results and the number still outstanding are handed to the top.
// ---------------------------------------------------------------------------
module flr_stream_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  flr_pkg::flr_in_t  in_item,
	input  logic              out_valid,
	input  logic              out_stall,
	input  flr_pkg::flr_out_t out_item,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                mismatches,
	output int                outstanding,
	output int                items_seen,
	output int                results_seen,
	output int                line_ends_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import flr_pkg::*;

	logic [15:0] max_line_q;
	logic        raw_mode_q;
	logic [1:0]  phase_q;
	logic [15:0] char_count_q;
	flr_out_t    unfolded_q[$];
	int          err_n;
	int          item_n;
	int          result_n;
	int          end_n;

	function automatic logic [15:0] fill_limit();
		logic [15:0] m;
		m = (max_line_q < 16'd3) ? 16'd3 : max_line_q;
		return m - 16'd1;
	endfunction

	function automatic logic [2:0] finished_status();
		return (char_count_q == 16'd1) ? ST_BLANK : ST_OK;
	endfunction

	task automatic emit_char(input logic [7:0] b);
		flr_out_t r;
		r.out_byte = b;
		r.line_end = 1'b0;
		r.status   = ST_OK;
		unfolded_q.push_back(r);
	endtask

	task automatic emit_end(input logic [2:0] st);
		flr_out_t r;
		r.out_byte = 8'd0;
		r.line_end = 1'b1;
		r.status   = st;
		unfolded_q.push_back(r);
		char_count_q = 16'd0;
		phase_q      = PH_LINE;
	endtask

	task automatic line_char(input logic [7:0] b);
		if (b == CH_NUL) begin
			emit_end(ST_RESYNC);
		end else begin
			char_count_q = char_count_q + 16'd1;
			if (b == CH_NL) begin
				if (raw_mode_q)
					emit_end(finished_status());
				else
					phase_q = PH_LOOK;
			end else begin
				emit_char(b);
				if (char_count_q >= fill_limit())
					emit_end(ST_LONG);
			end
		end
	endtask

	task automatic unfold_byte(input flr_in_t it);
		if (it.kind) begin
			if (phase_q == PH_LOOK || phase_q == PH_SKIP)
				emit_end(finished_status());
			emit_end(ST_EOF);
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (it.in_byte == CH_NL)
						phase_q = PH_LOOK;
				end
				PH_LOOK: begin
					if (it.in_byte == CH_HASH) begin
						phase_q = PH_SKIP;
					end else if (it.in_byte == CH_SPACE || it.in_byte == CH_TAB) begin
						phase_q = PH_LINE;
						emit_char(CH_SPACE);
						if (char_count_q >= fill_limit())
							emit_end(ST_LONG);
					end else begin
						emit_end(finished_status());
						line_char(it.in_byte);
					end
				end
				default: begin
					phase_q = PH_LINE;
					line_char(it.in_byte);
				end
			endcase
		end
	endtask

	task automatic check_result(input flr_out_t got);
		flr_out_t exp;
		result_n++;
		if (got.line_end === 1'b1)
			end_n++;
		if (unfolded_q.size() == 0) begin
			err_n++;
			if (err_n <= 10)
				$display("%0t: unexpected result byte %02h end %0b status %0d",
					$time, got.out_byte, got.line_end, got.status);
		end else begin
			exp = unfolded_q.pop_front();
			if (got.out_byte !== exp.out_byte || got.line_end !== exp.line_end ||
					got.status !== exp.status) begin
				err_n++;
				if (err_n <= 10)
					$display("%0t: mismatch exp %02h/%0b/%0d got %02h/%0b/%0d",
						$time, exp.out_byte, exp.line_end, exp.status,
						got.out_byte, got.line_end, got.status);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q   = MAX_LINE_RESET;
			raw_mode_q   = 1'b0;
			phase_q      = PH_LINE;
			char_count_q = 16'd0;
			unfolded_q.delete();
			err_n    = 0;
			item_n   = 0;
			result_n = 0;
			end_n    = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MAX_LINE)
					max_line_q = cfg_data;
				else
					raw_mode_q = cfg_data[0];
			end
			if (in_valid && !in_stall) begin
				item_n++;
				unfold_byte(in_item);
			end
			if (out_valid && !out_stall)
				check_result(out_item);
		end
		mismatches     <= err_n;
		outstanding    <= unfolded_q.size();
		items_seen     <= item_n;
		results_seen   <= result_n;
		line_ends_seen <= end_n;
	end

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Drives the folded line reader with directed text covering folding, comment
// skipping, blank lines, nul resync, overlong lines and end of input, then
// with random phases of mostly well-formed header text under varied line
// limits and raw mode, with bursty input and random output stalls.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import flr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASES       = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES  = 20;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	flr_in_t     in_item   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	flr_out_t    out_item;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = REG_MAX_LINE;
	logic [15:0] cfg_data  = '0;

	int mismatches;
	int outstanding;
	int items_seen;
	int results_seen;
	int line_ends_seen;
	int reg_writes = 0;
	int eof_sent   = 0;
	int cycle_count = 0;
	int stall_mode  = 0;
	int stretch_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	folded_line_reader i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	flr_stream_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.items_seen     (items_seen),
		.results_seen   (results_seen),
		.line_ends_seen (line_ends_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls in stretches: none, light, half or heavy
	always @(posedge clk) begin
		if (stretch_left == 0) begin
			stall_mode   <= $urandom_range(0, 3);
			stretch_left <= $urandom_range(1, 40);
		end else begin
			stretch_left <= stretch_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 7) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send_item(input flr_in_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		if (it.kind)
			eof_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		flr_in_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.kind    = 1'b0;
			it.in_byte = s[i];
			send_item(it);
		end
	endtask

	task automatic send_eof();
		flr_in_t it;
		it.kind    = 1'b1;
		it.in_byte = 8'($urandom);
		send_item(it);
	endtask

	task automatic send_byte(input logic [7:0] b);
		flr_in_t it;
		it.kind    = 1'b0;
		it.in_byte = b;
		send_item(it);
	endtask

	task automatic pause_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// header-like text: after a newline favor folds, comments and blank lines
	function automatic flr_in_t pick_item(input logic after_nl);
		flr_in_t it;
		int roll;
		roll       = $urandom_range(0, 99);
		it.kind    = 1'b0;
		it.in_byte = 8'($urandom_range(33, 126));
		if (after_nl) begin
			if (roll < 20)
				it.in_byte = CH_SPACE;
			else if (roll < 35)
				it.in_byte = CH_TAB;
			else if (roll < 55)
				it.in_byte = CH_HASH;
			else if (roll < 65)
				it.in_byte = CH_NL;
			else if (roll < 70)
				it.kind = 1'b1;
		end else begin
			if (roll < 14)
				it.in_byte = CH_NL;
			else if (roll < 17)
				it.in_byte = CH_NUL;
			else if (roll < 19)
				it.kind = 1'b1;
			else if (roll < 26)
				it.in_byte = 8'($urandom);
		end
		if (it.kind)
			it.in_byte = 8'($urandom);
		return it;
	endfunction

	initial begin
		flr_in_t     it;
		logic        after_nl;
		int          burst_left;
		logic        gaps_on;
		logic [15:0] ml;
		int          per_phase;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// folds, comments, comment then fold, blank line, nul, top byte, eof cases
		send_text("A\n B\n\tC\n#x\n#\n D\n\nE");
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_eof();
		send_text("\n");
		send_eof();
		send_text("q\n#");
		send_eof();
		send_eof();

		// tightest limit: overflow, fold at the limit, newline at the limit
		write_reg(REG_MAX_LINE, 16'd3);
		send_text("ab");
		send_text("a\n ");
		send_text("a\n\nz");
		write_reg(REG_MAX_LINE, 16'd0);
		send_text("\nxy");

		// raw mode switched on while a newline is pending
		write_reg(REG_MAX_LINE, 16'hFFFF);
		send_text("k\n");
		write_reg(REG_RAW_MODE, 16'd1);
		send_text("w\n\n# \t");
		send_eof();

		per_phase = RANDOM_ITEMS / PHASES;
		after_nl  = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ml = 16'd3;
				1: ml = 16'hFFFF;
				default: begin
					case ($urandom_range(0, 5))
						0: ml = 16'($urandom_range(0, 2));
						1, 2: ml = 16'($urandom_range(3, 12));
						3: ml = 16'($urandom_range(13, 80));
						4: ml = MAX_LINE_RESET;
						default: ml = 16'($urandom);
					endcase
				end
			endcase
			write_reg(REG_MAX_LINE, ml);
			write_reg(REG_RAW_MODE, (p == 2 || $urandom_range(0, 3) == 0) ? 16'd1 : 16'd0);
			gaps_on    = (p % 3 != 1);
			burst_left = $urandom_range(1, 30);
			for (int i = 0; i < per_phase; i++) begin
				if (p % 2 == 0 && i == per_phase / 2)
					drain();
				it = pick_item(after_nl);
				send_item(it);
				after_nl = (it.kind == 1'b0 && it.in_byte == CH_NL);
				if (gaps_on) begin
					burst_left--;
					if (burst_left == 0) begin
						pause_input($urandom_range(1, 8));
						burst_left = $urandom_range(1, 30);
					end
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items (%0d end-of-input marks), %0d results with %0d line ends",
			items_seen, eof_sent, results_seen, line_ends_seen);
		$display("%0d register writes over %0d random phases, %0d mismatches",
			reg_writes, PHASES, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ folded_line_reader.f @@
src/flr_pkg.sv
src/flr_step.sv
src/flr_out_queue.sv
src/folded_line_reader.sv
test/flr_stream_checker.sv
test/tb_top.sv
